### rtl/rps_pkg.sv
package rps_pkg;

    localparam int MAX_NODES = 1024;
    localparam int ADDR_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = 11;
    localparam int NODE_W    = 10;
    localparam int WORD_W    = 31;
    localparam int EPOCH_W   = 8;

    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_STEP    = 1'b1;

    localparam logic ST_PLACED    = 1'b0;
    localparam logic ST_EXHAUSTED = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [WORD_W-1:0] random_word;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0] node_id;
        logic [NODE_W-1:0] position;
        logic              last;
        logic              status;
    } t_out_item;

    typedef struct packed {
        logic [EPOCH_W-1:0] mark;
        logic [ADDR_W-1:0]  value;
    } t_ram_entry;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLEAR = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_RD_A  = 8'b0000_1000,
        S_RD_B  = 8'b0001_0000,
        S_WR_A  = 8'b0010_0000,
        S_WR_B  = 8'b0100_0000,
        S_PUSH  = 8'b1000_0000
    } t_state;

endpackage

### rtl/rps_ram.sv
module rps_ram
    import rps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_ram_entry        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_ram_entry        o_rdata
);

    t_ram_entry r_mem [MAX_NODES];
    t_ram_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rps_mod.sv
module rps_mod
    import rps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [CNT_W-1:0]  o_rem
);

    localparam int ITER_W = $clog2(WORD_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [ITER_W-1:0] r_cnt, n_cnt;
    logic [WORD_W-1:0] r_dvd, n_dvd;
    logic [CNT_W-1:0]  r_dvs, n_dvs;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_diff;

    // One dividend bit enters the partial remainder per cycle, MSB first.
    assign w_trial = {r_rem, r_dvd[WORD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = ITER_W'(WORD_W - 1);
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[WORD_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_dvs}) begin
                n_rem = w_diff[CNT_W-1:0];
            end else begin
                n_rem = w_trial[CNT_W-1:0];
            end
            n_cnt = r_cnt - ITER_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### rtl/random_permutation_shuffle.sv
// Random permutation generator, backward Fisher-Yates shuffle over node numbers.
// Input channel (i_in_valid, o_in_stall, i_in_data): a restart word arms a new
// permutation of node_count nodes; a step word hands out one node, placed at
// the next position from the top down. Output channel (o_out_valid,
// i_out_stall, o_out_data) carries one result word per step, none per restart.
// The user must write the node count through i_cfg_we / i_cfg_wdata while
// idle (the block does not enforce it); it is taken up at the next restart.
// A step passes from acceptance through the bit-serial remainder unit, then
// four table-access states (S_RD_A, S_RD_B, S_WR_A, S_WR_B), then the
// hand-off to the output register; no new item is accepted until that
// hand-off. A step with nothing left goes straight to the hand-off of its
// exhausted word.
// A restart leaves the block idle and ready for the next item, except that
// on the first restart after reset and on every 255th one after it the
// written marks are swept over all 1024 table entries, during which
// o_in_stall stays high.
// Reset leaves no permutation armed, so steps report exhausted until a restart.
// A result held by a stalled receiver sits in the output register; the next
// item may still be accepted, but the following result waits for it.
module random_permutation_shuffle
    import rps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_node_count;
    logic [CNT_W-1:0]   r_remaining, n_remaining;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0]  r_slot, n_slot;
    logic [ADDR_W-1:0]  r_picked, n_picked;
    t_out_item          r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic               w_accept;
    logic [ADDR_W-1:0]  w_top;
    logic [CNT_W-1:0]   w_count;
    logic [ADDR_W-1:0]  w_rd_value;
    logic               w_out_free;

    logic               w_mod_start;
    logic               w_mod_done;
    logic [CNT_W-1:0]   w_mod_rem;

    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    t_ram_entry         w_wdata;
    logic [ADDR_W-1:0]  w_raddr;
    t_ram_entry         w_rdata;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_top      = ADDR_W'(r_remaining - CNT_W'(1));
    assign w_count    = (r_node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : r_node_count;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_mod_start = w_accept && (i_in_data.operation == OP_STEP)
                         && (r_remaining != '0) && (r_remaining <= CNT_W'(MAX_NODES));

    rps_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (i_in_data.random_word),
        .i_divisor  (r_remaining),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    rps_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // An entry counts as written only if it carries the current epoch mark;
    // otherwise it reads as its own index.
    always_comb begin
        w_rd_value = (r_state == S_RD_B) ? r_slot : w_top;
        if (w_rdata.mark == r_epoch) begin
            w_rd_value = w_rdata.value;
        end
    end

    assign w_raddr = (r_state == S_RD_A) ? r_slot : w_top;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_top;
        w_wdata = '{mark: r_epoch, value: r_picked};
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
            end
            S_WR_A: begin
                w_we    = 1'b1;
                w_waddr = r_slot;
                w_wdata = '{mark: r_epoch, value: w_rd_value};
            end
            S_WR_B: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_remaining = r_remaining;
        n_epoch     = r_epoch;
        n_clr_addr  = r_clr_addr;
        n_slot      = r_slot;
        n_picked    = r_picked;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.operation == OP_RESTART) begin
                        n_remaining = w_count;
                        if (r_epoch == EPOCH_LAST) begin
                            n_epoch    = EPOCH_FIRST;
                            n_clr_addr = '0;
                            n_state    = S_CLEAR;
                        end else begin
                            n_epoch = r_epoch + EPOCH_W'(1);
                        end
                    end else if (w_mod_start) begin
                        n_state = S_DIV;
                    end else begin
                        n_res   = '{node_id: '0, position: '0, last: 1'b0,
                                    status: ST_EXHAUSTED};
                        n_state = S_PUSH;
                    end
                end
            end
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(MAX_NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (w_mod_done) begin
                    n_slot  = ADDR_W'(w_mod_rem);
                    n_state = S_RD_A;
                end
            end
            S_RD_A: begin
                n_state = S_RD_B;
            end
            S_RD_B: begin
                n_picked = w_rd_value;
                n_state  = S_WR_A;
            end
            S_WR_A: begin
                n_res   = '{node_id: NODE_W'(r_picked), position: NODE_W'(w_top),
                            last: (w_top == '0), status: ST_PLACED};
                n_state = S_WR_B;
            end
            S_WR_B: begin
                n_remaining = r_remaining - CNT_W'(1);
                n_state     = S_PUSH;
            end
            S_PUSH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= CNT_W'(1024);
            r_remaining  <= '0;
            r_epoch      <= EPOCH_LAST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_remaining <= n_remaining;
            r_epoch     <= n_epoch;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_clr_addr <= n_clr_addr;
        r_slot     <= n_slot;
        r_picked   <= n_picked;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_remaining_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remaining <= CNT_W'(MAX_NODES))
        else $error("remaining count above table depth");

    a_mod_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == S_DIV))
        else $error("remainder unit finished outside a step");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_A) |-> ({1'b0, r_slot} < r_remaining))
        else $error("picked slot not below remaining count");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR_B) |=> (r_remaining == $past(r_remaining) - CNT_W'(1)))
        else $error("remaining count did not step down after a placement");
`endif

endmodule
